// ===== src/assert_macros.svh =====
// Assertion macros used by the checker, cpbr_chk.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, ignored while reset is asserted
`define CPBR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset
`define CPBR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/cpbr_pkg.sv =====
// Shared types, constants and the key function of the protection bank registers.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package cpbr_pkg;

  // Address region codes, taken from addr[14:11]
  localparam logic [3:0] REG_BANK_LO = 4'b1001;  // 0x4800-0x4FFF
  localparam logic [3:0] REG_INDEX   = 4'b1010;  // 0x5000-0x57FF
  localparam logic [3:0] REG_LATCH   = 4'b1011;  // 0x5800-0x5FFF
  localparam logic [3:0] REG_BANK_HI = 4'b1101;  // 0x6800-0x6FFF

  // Access kinds
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  localparam logic [8:0] ROM_PAGES_RST = 9'd16;
  localparam logic [1:0] BANK_RST      = 2'd3;
  localparam logic [1:0] STEP_LAST     = 2'd3;
  localparam int         NUM_LANES     = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } cpbr_state_t;

  typedef struct packed {
    logic       accept;
    logic       step_en;
    logic [1:0] step;
    logic       load_out;
  } cpbr_cmd_t;

  typedef struct packed {
    logic out_free;
  } cpbr_sts_t;

  // XOR key derived from the index byte
  function automatic logic [7:0] prot_key(input logic [7:0] idx);
    logic [7:0] base;
    logic [7:0] flip;
    base = idx[6] ? 8'h00 : 8'h59;
    flip = 8'h00;
    if (idx[3] ^ idx[6]) begin
      if (idx[1]) flip = flip | 8'h40;
      if (idx[0]) flip = flip | 8'h10;
      if (idx[4]) flip = flip | 8'h08;
      if (idx[7]) flip = flip | 8'h01;
    end
    return base ^ flip;
  endfunction

endpackage

// ===== src/cartridge_protection_bank_regs.sv =====
// Protection and bank registers of a cartridge board: one CPU bus access per
// transaction, one result per access. The bank, index and latch registers
// update at the accept edge. Four restoring steps of the page modulo follow
// (all four pages in parallel lanes, one dividend bit a step), and then the
// output register is loaded. The input is ready again in the cycle after the
// load, so a new access is taken only once the last one is through. A result
// still waiting in the output register holds the next load back, and with it
// the input.
// Depends on cpbr_pkg, cpbr_ctrl and cpbr_dp.
`timescale 1ns / 1ps

module cartridge_protection_bank_regs
  import cpbr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // addr[14:0], wdata[22:15], zero pad
  input  logic [0:0]  in_tuser,    // func[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // rdata, prg_bank, page0..page3, zero pad
  output logic [0:0]  out_tuser,   // read_hit[0]
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data  // rom_pages
);

  cpbr_cmd_t  cmd;
  cpbr_sts_t  sts;
  logic [7:0] rdata;
  logic       read_hit;
  logic [1:0] prg_bank;
  logic [8:0] page0, page1, page2, page3;

  cpbr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cpbr_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_func      (in_tuser[0]),
    .in_addr      (in_tdata[14:0]),
    .in_wdata     (in_tdata[22:15]),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_rdata    (rdata),
    .out_read_hit (read_hit),
    .out_prg_bank (prg_bank),
    .out_page0    (page0),
    .out_page1    (page1),
    .out_page2    (page2),
    .out_page3    (page3)
  );

  // Pack the result transaction
  assign out_tdata = {2'b00, page3, page2, page1, page0, prg_bank, rdata};
  assign out_tuser = read_hit;

endmodule

// ===== src/cpbr_ctrl.sv =====
// Controller of the protection bank registers: sequences accept, modulo steps
// and output load. Depends on cpbr_pkg.
`timescale 1ns / 1ps

module cpbr_ctrl
  import cpbr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  cpbr_sts_t sts,
  output cpbr_cmd_t cmd
);

  cpbr_state_t state_r, state_nxt;
  logic [1:0]  step_r, step_nxt;

  // State and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_tvalid) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        step_nxt = step_r + 2'd1;
        if (step_r == STEP_LAST) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_tready    = 1'b0;
    cmd.accept   = 1'b0;
    cmd.step_en  = 1'b0;
    cmd.step     = step_r;
    cmd.load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ST_DIV:  cmd.step_en = 1'b1;
      ST_DONE: cmd.load_out = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ===== src/cpbr_dp.sv =====
// Datapath of the protection bank registers: bank, index and latch state,
// four restoring modulo lanes and the output register. Depends on cpbr_pkg.
`timescale 1ns / 1ps

module cpbr_dp
  import cpbr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cpbr_cmd_t  cmd,
  output cpbr_sts_t  sts,
  input  logic       in_func,
  input  logic [14:0] in_addr,
  input  logic [7:0] in_wdata,
  input  logic       cfg_wr_en,
  input  logic [8:0] cfg_wr_data,
  input  logic       out_tready,
  output logic       out_tvalid,
  output logic [7:0] out_rdata,
  output logic       out_read_hit,
  output logic [1:0] out_prg_bank,
  output logic [8:0] out_page0,
  output logic [8:0] out_page1,
  output logic [8:0] out_page2,
  output logic [8:0] out_page3
);

  logic [8:0] rom_pages_r;
  logic [7:0] latch_r [4];
  logic [7:0] xor_index_r;
  logic [1:0] bank_r;
  logic [7:0] rdata_r;
  logic       hit_r;
  logic [3:0] rem_r [NUM_LANES];
  logic [3:0] rem_nxt [NUM_LANES];
  logic       out_valid_r;
  logic [7:0] out_rdata_r;
  logic       out_hit_r;
  logic [1:0] out_bank_r;
  logic [8:0] out_page_r [NUM_LANES];

  logic [3:0] region;
  logic       is_latch, is_index, is_bank;
  logic [1:0] bank_nxt;

  assign region   = in_addr[14:11];
  assign is_latch = (region == REG_LATCH);
  assign is_index = (region == REG_INDEX);
  assign is_bank  = (region == REG_BANK_LO) || (region == REG_BANK_HI);

  // New bank value for this transaction
  always_comb begin
    bank_nxt = bank_r;
    if (in_func == FUNC_WRITE && is_bank) bank_nxt = {in_wdata[4], in_wdata[0]};
  end

  // Page count register
  always_ff @(posedge clk) begin
    if (!rst_n) rom_pages_r <= ROM_PAGES_RST;
    else if (cfg_wr_en) rom_pages_r <= cfg_wr_data;
  end

  // Bank, index and latch state, updated on an accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r      <= BANK_RST;
      xor_index_r <= '0;
      for (int i = 0; i < 4; i++) latch_r[i] <= '0;
    end else if (cmd.accept) begin
      bank_r <= bank_nxt;
      if (in_func == FUNC_WRITE && is_index) xor_index_r <= in_wdata;
      if (in_func == FUNC_WRITE && is_latch)
        latch_r[in_addr[1:0]] <= in_wdata ^ prot_key(xor_index_r);
    end
  end

  // Read answer, captured at accept
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hit_r   <= (in_func == FUNC_READ) && is_latch;
      rdata_r <= ((in_func == FUNC_READ) && is_latch) ? latch_r[in_addr[1:0]] : 8'h00;
    end
  end

  // One restoring step per lane: shift in the next dividend bit, subtract if it fits
  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      logic [3:0] dvd;
      logic [4:0] trial;
      dvd   = {bank_r, 2'(k)};
      trial = {rem_r[k], dvd[STEP_LAST - cmd.step]};
      if ({4'b0, trial} >= rom_pages_r) rem_nxt[k] = 4'(trial - rom_pages_r[4:0]);
      else rem_nxt[k] = trial[3:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_LANES; k++) begin
      if (cmd.accept) rem_r[k] <= '0;
      else if (cmd.step_en) rem_r[k] <= rem_nxt[k];
    end
  end

  // Output register: hold until taken, load when free
  assign sts.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.load_out) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_rdata_r <= rdata_r;
      out_hit_r   <= hit_r;
      out_bank_r  <= bank_r;
      for (int k = 0; k < NUM_LANES; k++)
        out_page_r[k] <= (rom_pages_r == 9'd0) ? 9'd0 : {5'b0, rem_r[k]};
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_rdata    = out_rdata_r;
  assign out_read_hit = out_hit_r;
  assign out_prg_bank = out_bank_r;
  assign out_page0    = out_page_r[0];
  assign out_page1    = out_page_r[1];
  assign out_page2    = out_page_r[2];
  assign out_page3    = out_page_r[3];

endmodule

// ===== src/cpbr_chk.sv =====
// Port-level checker for the protection bank registers, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpbr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // Reset empties the output register
  `CPBR_ASSERT_RST(a_rst_out_empty, !rst_n |=> !out_tvalid, "out_tvalid after reset")

  // A stalled result stays offered and unchanged
  `CPBR_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped")
  `CPBR_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata), "result changed")

  // The block is busy with the modulo right after an accept
  `CPBR_ASSERT(a_busy_after_accept, in_tvalid && in_tready |=> !in_tready, "accept while busy")

  // Without a hit the read byte is zero
  `CPBR_ASSERT(a_miss_zero, out_tvalid && !out_tuser[0] |-> out_tdata[7:0] == 8'h00, "miss data")

endmodule

bind cartridge_protection_bank_regs cpbr_chk u_cpbr_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
